@@ src/gsm_frame_bit_packer_core_assert.svh @@
// ---------------------------------------------------------------------------
// GSM frame bit packer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef GSM_FRAME_BIT_PACKER_CORE_ASSERT_SVH
`define GSM_FRAME_BIT_PACKER_CORE_ASSERT_SVH

// same-cycle implication
`define GFBP_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GFBP_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

@@ src/gfbp_pkg.sv @@
// ---------------------------------------------------------------------------
// GSM frame bit packer package
// Frame layout constants and the per-field bit width table.
// ---------------------------------------------------------------------------
package gfbp_pkg;

	localparam int FIELDS_PER_FRAME = 76;
	localparam int IDX_W            = $clog2(FIELDS_PER_FRAME);

	localparam logic [IDX_W-1:0] LAST_FIELD = IDX_W'(FIELDS_PER_FRAME - 1);

	localparam logic [7:0] SIGNATURE      = 8'h0d;
	localparam logic [2:0] SIGNATURE_BITS = 3'd4;

	typedef logic [IDX_W-1:0] field_idx_t;
	typedef logic [2:0]       bit_pos_t;
	typedef logic [6:0]       param_t;
	typedef logic [7:0]       frame_byte_t;

	localparam logic [2:0] FIELD_WIDTH [FIELDS_PER_FRAME] = '{
		3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd3,
		3'd7, 3'd2, 3'd2, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd7, 3'd2, 3'd2, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd7, 3'd2, 3'd2, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd7, 3'd2, 3'd2, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
	};

	typedef struct packed {
		logic        valid;
		param_t      value;
	} in_stage_t;

endpackage

@@ src/gsm_frame_bit_packer_core.sv @@
// ---------------------------------------------------------------------------
// GSM frame bit packer core
// Packs the 76 coded parameters of a GSM full-rate frame into 33 bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, param_value) takes one parameter item
//   per cycle, in frame order; only the low bits of each field's width count.
//   Output channel (out_valid, out_stall, frame_byte, last_of_frame) gives
//   each completed byte, earliest bit in bit 0; last_of_frame marks the 33rd.
//   A 4-bit signature 0x0d leads every frame.
//   An item is taken into the input register; the byte it completes is then
//   registered in the result register and shows on out_valid.
//   Throughput: one item per cycle unless out_stall holds a byte, set by the
//   combinational merge between the input register and the byte register.
//   Stall: while a byte waits under out_stall, the input register still
//   takes one item; further items see in_stall until the byte is taken.
//   Reset: arst_n clears the pending bits and starts at the first field.
// ---------------------------------------------------------------------------
module gsm_frame_bit_packer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  gfbp_pkg::param_t      param_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output gfbp_pkg::frame_byte_t frame_byte,
	output logic                  last_of_frame
);
	import gfbp_pkg::*;

	in_stage_t stage_s1;
	logic      advance;

	gfbp_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.param_value (param_value),
		.advance     (advance),
		.stage_s1    (stage_s1)
	);

	gfbp_packer u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.stage_s1      (stage_s1),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.last_of_frame (last_of_frame)
	);

endmodule

@@ src/gfbp_in_stage.sv @@
// ---------------------------------------------------------------------------
// GSM frame bit packer input stage
// Registers one parameter item and holds it until the packer takes it.
// ---------------------------------------------------------------------------
module gfbp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gfbp_pkg::param_t   param_value,
	input  logic               advance,
	output gfbp_pkg::in_stage_t stage_s1
);
	import gfbp_pkg::*;

	logic   valid_s1;
	param_t value_s1;

	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			value_s1 <= param_value;
		end
	end

	assign stage_s1.valid = valid_s1;
	assign stage_s1.value = value_s1;

endmodule

@@ src/gfbp_packer.sv @@
// ---------------------------------------------------------------------------
// GSM frame bit packer merge stage
// Merges the masked field into the pending bits and registers each full byte.
// ---------------------------------------------------------------------------
module gfbp_packer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gfbp_pkg::in_stage_t     stage_s1,
	output logic                    advance,
	output logic                    out_valid,
	input  logic                    out_stall,
	output gfbp_pkg::frame_byte_t   frame_byte,
	output logic                    last_of_frame
);
	import gfbp_pkg::*;

	field_idx_t  field_idx_q;
	bit_pos_t    bit_pos_q;
	frame_byte_t acc_q;
	logic        out_valid_q;
	frame_byte_t byte_q;
	logic        last_q;

	field_idx_t  idx;
	logic        first;
	logic        last;
	logic [2:0]  width;
	param_t      mask;
	param_t      value;
	frame_byte_t base;
	bit_pos_t    pos;
	logic [14:0] merged;
	logic [3:0]  pos_sum;
	logic        emit;

	always_comb begin
		idx     = (field_idx_q > LAST_FIELD) ? '0 : field_idx_q;
		first   = (idx == '0);
		last    = (idx == LAST_FIELD);
		width   = FIELD_WIDTH[idx];
		mask    = 7'((8'd1 << width) - 8'd1);
		value   = stage_s1.value & mask;
		base    = first ? SIGNATURE : acc_q;
		pos     = first ? SIGNATURE_BITS : bit_pos_q;
		merged  = {7'd0, base} | ({8'd0, value} << pos);
		pos_sum = {1'b0, pos} + {1'b0, width};
		emit    = pos_sum[3];
	end

	assign advance = stage_s1.valid & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_idx_q <= '0;
			bit_pos_q   <= '0;
			acc_q       <= '0;
		end else if (advance) begin
			field_idx_q <= last ? '0 : idx + 1'b1;
			bit_pos_q   <= pos_sum[2:0];
			acc_q       <= emit ? {1'b0, merged[14:8]} : merged[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			byte_q <= merged[7:0];
			last_q <= last;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_byte    = byte_q;
	assign last_of_frame = last_q;

	`include "gsm_frame_bit_packer_core_assert.svh"

	`GFBP_ASSERT_NOW(a_idx_range, 1'b1, field_idx_q <= LAST_FIELD,
		"field index beyond frame")
	`GFBP_ASSERT_NOW(a_frame_aligned, field_idx_q == '0, bit_pos_q == '0,
		"frame start not on byte boundary")
	`GFBP_ASSERT_NEXT(a_last_emits, advance && last,
		out_valid_q && last_q && field_idx_q == '0, "last field did not end frame")
	`GFBP_ASSERT_NOW(a_no_overwrite, out_valid_q && out_stall, !advance,
		"held byte overwritten")

endmodule

@@ test/gsm_frame_bit_packer_core_tb.sv @@
// ---------------------------------------------------------------------------
// GSM frame bit packer core testbench
// Feeds parameter items in frame order through the valid/stall input channel:
// a short directed run of extremes, then random frames mixing in-range,
// out-of-range, zero and all-ones values. It randomly idles the sender and
// stalls the receiver. Every byte taken from the output is checked against a
// bit-accurate packing model kept here.
// ---------------------------------------------------------------------------
module gsm_frame_bit_packer_core_tb;

	import gfbp_pkg::param_t;
	import gfbp_pkg::frame_byte_t;

	localparam int N_FIELDS    = 76;
	localparam int N_DIRECTED  = 25;
	localparam int N_RANDOM    = 1500;
	localparam int N_ITEMS     = N_DIRECTED + N_RANDOM;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_TAIL  = 10;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		frame_byte_t b;
		logic        last;
	} packed_byte_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	param_t      param_value;
	logic        out_valid;
	logic        out_stall;
	frame_byte_t frame_byte;
	logic        last_of_frame;

	gsm_frame_bit_packer_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.param_value  (param_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.last_of_frame(last_of_frame)
	);

	param_t       param_pending[$];
	packed_byte_t byte_expect[$];

	logic [7:0] acc_bits;
	logic [2:0] acc_count;
	int         next_field;

	int  items_in;
	int  bytes_out;
	int  frames_out;
	int  mismatches;
	int  idle_cycles;
	bit  in_taken;
	int  in_gap_left;
	int  stall_left;
	bit  calm;

	function automatic int field_bits(input int idx);
		int k;
		if (idx < 8) begin
			case (idx)
				0, 1: return 6;
				2, 3: return 5;
				4, 5: return 4;
				default: return 3;
			endcase
		end
		k = (idx - 8) % 17;
		case (k)
			0: return 7;
			1, 2: return 2;
			3: return 6;
			default: return 3;
		endcase
	endfunction

	task automatic pack_param(input param_t v);
		int          w;
		logic [15:0] merged;
		logic [4:0]  pos;
		logic [6:0]  masked;
		bit          last;
		w = field_bits(next_field);
		masked = v & 7'((1 << w) - 1);
		if (next_field == 0) begin
			merged = 16'h000d;
			pos = 5'd4;
		end else begin
			merged = {8'h00, acc_bits};
			pos = {2'b00, acc_count};
		end
		merged = merged | (16'(masked) << pos);
		pos = pos + 5'(w);
		last = (next_field == N_FIELDS - 1);
		if (pos >= 5'd8) begin
			byte_expect.push_back('{b: merged[7:0], last: last});
			merged = merged >> 8;
			pos = pos - 5'd8;
		end
		acc_bits = merged[7:0];
		acc_count = pos[2:0];
		next_field = last ? 0 : next_field + 1;
	endtask

	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 149) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always #5 clk = ~clk;

	always @(posedge clk) begin
		packed_byte_t exp_b;
		bit           moved;
		in_taken = 0;
		moved = 0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pack_param(param_value);
				items_in++;
				in_taken = 1;
				moved = 1;
			end
			if (out_valid && !out_stall) begin
				moved = 1;
				bytes_out++;
				if (last_of_frame)
					frames_out++;
				if (byte_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected byte %02h last %0b", frame_byte, last_of_frame);
				end else begin
					exp_b = byte_expect.pop_front();
					if (frame_byte !== exp_b.b || last_of_frame !== exp_b.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("byte %0d: expected %02h last %0b, got %02h last %0b",
								bytes_out, exp_b.b, exp_b.last, frame_byte, last_of_frame);
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("gsm_frame_bit_packer_core_tb NOT OK");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// hold the stalled item
			end else if (in_gap_left > 0) begin
				in_valid <= 1'b0;
				in_gap_left--;
			end else if (param_pending.size() > 0) begin
				param_value <= param_pending.pop_front();
				in_valid <= 1'b1;
				in_gap_left = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		int     pos;
		int     w;
		param_t v;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		param_value = '0;
		out_stall = 1'b0;
		acc_bits = '0;
		acc_count = '0;
		next_field = 0;
		items_in = 0;
		bytes_out = 0;
		frames_out = 0;
		mismatches = 0;
		idle_cycles = 0;
		in_taken = 0;
		in_gap_left = 0;
		stall_left = 0;
		calm = 0;

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (i < 8)
				param_pending.push_back(7'h7f);
			else
				param_pending.push_back((i % 2) ? 7'h00 : 7'h7f);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			pos = (N_DIRECTED + i) % N_FIELDS;
			w = field_bits(pos);
			case ($urandom_range(0, 9))
				0: v = 7'h00;
				1: v = 7'h7f;
				2, 3, 4: v = 7'($urandom_range(0, 127));
				default: v = 7'($urandom_range(0, (1 << w) - 1));
			endcase
			param_pending.push_back(v);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (items_in < N_ITEMS)
			@(posedge clk);
		while (byte_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("%0d parameter items packed, %0d bytes checked, %0d complete frames",
			items_in, bytes_out, frames_out);
		$display("%0d mismatched bytes", mismatches);
		if (mismatches == 0 && byte_expect.size() == 0)
			$display("gsm_frame_bit_packer_core_tb OK");
		else
			$display("gsm_frame_bit_packer_core_tb NOT OK");
		$finish;
	end

endmodule
